>>> hw/rtl/bcth_pkg.sv
`default_nettype none

package bcth_pkg;

  // fixed field widths of the ports
  localparam int ACTION_W    = 2;
  localparam int WORD_W      = 32;
  localparam int BIN_W       = 15;
  localparam int OUT_COUNT_W = 64;
  localparam int BUCKET_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  // popcount of a word and the counters compared with it
  localparam int ONES_W = 6;
  localparam int SEEN_W = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  // actions
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_CNT  = 2'd3;

  // configuration reset values
  localparam logic              GRAY_MODE_RST = 1'b1;
  localparam logic [ONES_W-1:0] LOW_THR_RST   = 6'd14;
  localparam logic [ONES_W-1:0] HIGH_THR_RST  = 6'd19;
  localparam logic [SEEN_W-1:0] PRIME_CNT_RST = 6'd32;

  // bucket codes
  localparam logic [BUCKET_W-1:0] BKT_LOW  = 2'd0;
  localparam logic [BUCKET_W-1:0] BKT_MID  = 2'd1;
  localparam logic [BUCKET_W-1:0] BKT_HIGH = 2'd2;

  // masks of the pairwise popcount tree
  localparam logic [WORD_W-1:0] POP_M1  = 32'h5555_5555;
  localparam logic [WORD_W-1:0] POP_M2  = 32'h3333_3333;
  localparam logic [WORD_W-1:0] POP_M4  = 32'h0f0f_0f0f;
  localparam logic [WORD_W-1:0] POP_M8  = 32'h00ff_00ff;
  localparam logic [WORD_W-1:0] POP_M16 = 32'h0000_ffff;

  // result queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_LVL_W = 2;
  localparam int FIFO_PTR_W = 2;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [BIN_W-1:0]       bin_touched;
    logic [BUCKET_W-1:0]    sample_bucket;
    logic                   counted;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bcth_bucket.sv
`default_nettype none

module bcth_bucket (
  input  logic [bcth_pkg::WORD_W-1:0]   word,
  input  logic                          gray_mode,
  input  logic [bcth_pkg::ONES_W-1:0]   low_thr,
  input  logic [bcth_pkg::ONES_W-1:0]   high_thr,
  output logic [bcth_pkg::BUCKET_W-1:0] bucket
);
  import bcth_pkg::*;

  logic [WORD_W-1:0] v0, v1, v2, v3, v4, v5;
  logic [ONES_W-1:0] ones;

  // gray code drops the bit shifted out at the top
  assign v0 = gray_mode ? (word ^ {word[WORD_W-2:0], 1'b0}) : word;

  assign v1 = (v0 & POP_M1)  + ((v0 >> 1)  & POP_M1);
  assign v2 = (v1 & POP_M2)  + ((v1 >> 2)  & POP_M2);
  assign v3 = (v2 & POP_M4)  + ((v2 >> 4)  & POP_M4);
  assign v4 = (v3 & POP_M8)  + ((v3 >> 8)  & POP_M8);
  assign v5 = (v4 & POP_M16) + ((v4 >> 16) & POP_M16);
  assign ones = v5[ONES_W-1:0];

  // low threshold wins when thresholds cross
  always_comb begin
    if (ones < low_thr) begin
      bucket = BKT_LOW;
    end else if (ones >= high_thr) begin
      bucket = BKT_HIGH;
    end else begin
      bucket = BKT_MID;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bcth_result_fifo.sv
`default_nettype none

module bcth_result_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  bcth_pkg::result_t                push_data,
  input  logic                             pop,
  output bcth_pkg::result_t                head,
  output logic [bcth_pkg::FIFO_LVL_W-1:0]  level
);
  import bcth_pkg::*;

  result_t               entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_LVL_W-1:0] level_r;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    ptr_inc = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign level = level_r;

endmodule

`default_nettype wire

>>> hw/rtl/bitcount_tuple_histogram.sv
`default_nettype none

// Bit-count tuple histogram for checking a random generator. Each sample item
// (action 0) is optionally gray coded, its set bits are counted and mapped to
// bucket 0/1/2 by low_threshold and high_threshold; the buckets of the last
// WINDOW_LEN samples, newest in the low bits, select one of
// 2**(WINDOW_LEN*LOG_BUCKETS) bins, which is incremented and saturates at the
// largest COUNT_BITS-bit value. The first prime_count samples only fill the
// window and report counted=0. Action 1 reads one bin, action 2 clears it, and
// every item gives exactly one result item. Rate: one item per cycle while the
// result queue has room. Each item reads its bin from the histogram memory at
// the edge it is accepted and the modify stage writes the updated count back
// in the cycle after; an item that hits the bin written in that same edge
// takes the value from a forwarding register. Results pass the modify stage
// and leave through a three-entry queue, so the input stalls only when that
// queue backs up or during the clearing sweep. After reset the block sweeps
// all 2**(WINDOW_LEN*LOG_BUCKETS) bins (32768 at the default parameters) to
// zero, one bin per cycle, holding in_stall high; configuration writes are
// taken throughout. Configuration registers: 0 gray_mode, 1 low_threshold,
// 2 high_threshold, 3 prime_count; cfg_ready is always high.
module bitcount_tuple_histogram #(
  parameter int LOG_BUCKETS = 3,
  parameter int WINDOW_LEN  = 5,
  parameter int COUNT_BITS  = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bcth_pkg::ACTION_W-1:0]       in_action,
  input  logic [bcth_pkg::WORD_W-1:0]         in_sample_word,
  input  logic [bcth_pkg::BIN_W-1:0]          in_bin_select,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bcth_pkg::OUT_COUNT_W-1:0]    out_bin_count,
  output logic [bcth_pkg::BIN_W-1:0]          out_bin_touched,
  output logic [bcth_pkg::BUCKET_W-1:0]       out_sample_bucket,
  output logic                                out_counted,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bcth_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcth_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bcth_pkg::*;

  localparam int HIST_BITS  = WINDOW_LEN * LOG_BUCKETS;
  localparam int HIST_DEPTH = 1 << HIST_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  // configuration registers
  logic              gray_mode_r;
  logic [ONES_W-1:0] low_thr_r;
  logic [ONES_W-1:0] high_thr_r;
  logic [SEEN_W-1:0] prime_cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_mode_r <= GRAY_MODE_RST;
      low_thr_r   <= LOW_THR_RST;
      high_thr_r  <= HIGH_THR_RST;
      prime_cnt_r <= PRIME_CNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAY_MODE: gray_mode_r <= cfg_wdata[0];
        CFG_LOW_THR:   low_thr_r   <= cfg_wdata[ONES_W-1:0];
        CFG_HIGH_THR:  high_thr_r  <= cfg_wdata[ONES_W-1:0];
        CFG_PRIME_CNT: prime_cnt_r <= cfg_wdata[SEEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep after reset
  state_t               state_r;
  logic [HIST_BITS-1:0] clr_addr_r;
  logic                 clearing;

  assign clearing = (state_r == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

  // input side: bucket, window and bin address
  logic                   in_accept;
  logic                   is_sample;
  logic [BUCKET_W-1:0]    cur_bucket;
  logic                   counting;
  logic [LOG_BUCKETS-1:0] recent_r [WINDOW_LEN-1];
  logic [SEEN_W-1:0]      samples_seen_r;
  logic [HIST_BITS-1:0]   sample_idx;
  logic [HIST_BITS-1:0]   rd_addr;

  bcth_bucket u_bucket (
    .word      (in_sample_word),
    .gray_mode (gray_mode_r),
    .low_thr   (low_thr_r),
    .high_thr  (high_thr_r),
    .bucket    (cur_bucket)
  );

  assign in_accept = in_valid && !in_stall;
  assign is_sample = (in_action == ACT_SAMPLE);
  assign counting  = (samples_seen_r >= prime_cnt_r);

  // newest bucket in the low bits, older ones above
  always_comb begin
    sample_idx = '0;
    sample_idx[LOG_BUCKETS-1:0] = LOG_BUCKETS'(cur_bucket);
    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      sample_idx[(k + 1) * LOG_BUCKETS +: LOG_BUCKETS] = recent_r[k];
    end
  end

  assign rd_addr = is_sample ? sample_idx : in_bin_select[HIST_BITS-1:0];

  // window shifts on every sample, priming ones included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        recent_r[k] <= '0;
      end
      samples_seen_r <= '0;
    end else if (in_accept && is_sample) begin
      recent_r[0] <= LOG_BUCKETS'(cur_bucket);
      for (int k = 1; k < WINDOW_LEN - 1; k++) begin
        recent_r[k] <= recent_r[k-1];
      end
      if (samples_seen_r != SEEN_MAX) begin
        samples_seen_r <= samples_seen_r + 1'b1;
      end
    end
  end

  // histogram memory, one write and one registered read per cycle
  logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];
  logic [COUNT_BITS-1:0] mem_q_r;
  logic                  mem_we;
  logic [HIST_BITS-1:0]  mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // modify stage: the item whose bin read is in flight
  logic                  s1_valid_r;
  logic [ACTION_W-1:0]   s1_action_r;
  logic [BUCKET_W-1:0]   s1_bucket_r;
  logic                  s1_count_r;
  logic [HIST_BITS-1:0]  s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_action;
      s1_bucket_r <= is_sample ? cur_bucket : BKT_LOW;
      s1_count_r  <= counting;
      s1_addr_r   <= rd_addr;
    end
  end

  // last write, for a read that raced it in the same edge
  logic                  fwd_valid_r;
  logic [HIST_BITS-1:0]  fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_addr_r <= mem_waddr;
      fwd_data_r <= mem_wdata;
    end
  end

  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] inc_cnt;
  logic                  s1_we;
  logic [COUNT_BITS-1:0] s1_wdata;
  result_t               s1_res;

  assign old_cnt = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : mem_q_r;
  // saturate at the all-ones count
  assign inc_cnt = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;

  always_comb begin
    s1_we    = 1'b0;
    s1_wdata = inc_cnt;
    s1_res   = '0;
    case (s1_action_r)
      ACT_SAMPLE: begin
        s1_res.sample_bucket = s1_bucket_r;
        if (s1_count_r) begin
          s1_we              = 1'b1;
          s1_res.bin_count   = OUT_COUNT_W'(inc_cnt);
          s1_res.bin_touched = BIN_W'(s1_addr_r);
          s1_res.counted     = 1'b1;
        end
      end
      ACT_READ: begin
        s1_res.bin_count   = OUT_COUNT_W'(old_cnt);
        s1_res.bin_touched = BIN_W'(s1_addr_r);
      end
      ACT_CLEAR: begin
        s1_we              = 1'b1;
        s1_wdata           = '0;
        s1_res.bin_touched = BIN_W'(s1_addr_r);
      end
      default: ;
    endcase
  end

  // sweep owns the write port until the run state
  assign mem_we    = clearing || (s1_valid_r && s1_we);
  assign mem_waddr = clearing ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clearing ? '0 : s1_wdata;

  // result queue
  result_t               head;
  logic [FIFO_LVL_W-1:0] fifo_level;
  logic                  out_pop;

  assign out_pop = out_valid && !out_stall;

  bcth_result_fifo u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (s1_res),
    .pop       (out_pop),
    .head      (head),
    .level     (fifo_level)
  );

  // admit only if the queue has room for this item and the one in flight
  assign in_stall = clearing ||
                    (({1'b0, fifo_level} + {{FIFO_LVL_W{1'b0}}, s1_valid_r})
                     >= (FIFO_LVL_W + 1)'(FIFO_DEPTH));

  assign out_valid         = (fifo_level != '0);
  assign out_bin_count     = head.bin_count;
  assign out_bin_touched   = head.bin_touched;
  assign out_sample_bucket = head.sample_bucket;
  assign out_counted       = head.counted;

  // queue never receives an item it cannot hold
  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (fifo_level != FIFO_LVL_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // no item enters while the histogram is being swept
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_accept)
    else $error("item accepted during clearing sweep");

  // an incremented bin is never reported as empty
  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_counted) |-> (out_bin_count != '0))
    else $error("counted result with zero bin count");

  // a sample result never carries a bucket code above two
  a_bucket_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_bucket == BKT_LOW || out_sample_bucket == BKT_MID ||
                   out_sample_bucket == BKT_HIGH))
    else $error("bad bucket code in result");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bcth_pkg::*;

  // block geometry at its default parameters
  localparam int LOG_BUCKETS = 3;
  localparam int WINDOW_LEN  = 5;
  localparam int N_BINS      = 1 << (LOG_BUCKETS * WINDOW_LEN);

  // action code the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // idling per random phase, in percent
  localparam int SEND_IDLE_PCT [4] = '{0, 80, 0, 37};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 80, 37};
  localparam int ITEMS_PER_PHASE   = 225;
  localparam int LONG_HOLD_CYCLES  = 64;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // one row of the directed table: an item or a register write
  typedef struct {
    row_kind_t             kind;
    logic [ACTION_W-1:0]   action;
    logic [WORD_W-1:0]     word;
    logic [BIN_W-1:0]      sel;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    bit                    has_fixed;
    result_t               fixed_want;
  } row_t;

  logic clk;
  logic rst_n = 1'b0;

  // item input side
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action      = ACT_SAMPLE;
  logic [WORD_W-1:0]   in_sample_word = '0;
  logic [BIN_W-1:0]    in_bin_select  = '0;

  // result side
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [OUT_COUNT_W-1:0] out_bin_count;
  logic [BIN_W-1:0]       out_bin_touched;
  logic [BUCKET_W-1:0]    out_sample_bucket;
  logic                   out_counted;

  // register write side
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_GRAY_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // our own copy of the histogram state and settings
  logic [OUT_COUNT_W-1:0] bin_counts [N_BINS];
  logic [LOG_BUCKETS-1:0] window_buckets [WINDOW_LEN-1];
  logic [SEEN_W-1:0]      seen_count;
  logic                   cfg_gray;
  logic [ONES_W-1:0]      cfg_low;
  logic [ONES_W-1:0]      cfg_high;
  logic [SEEN_W-1:0]      cfg_prime;

  result_t          expected_results [$];
  logic [BIN_W-1:0] hot_bins [$];      // recently incremented bins, aimed at by reads and clears
  row_t             directed_rows [$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;

  bitcount_tuple_histogram #(
    .LOG_BUCKETS(LOG_BUCKETS),
    .WINDOW_LEN (WINDOW_LEN),
    .COUNT_BITS (OUT_COUNT_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_sample_word   (in_sample_word),
    .in_bin_select    (in_bin_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bin_count    (out_bin_count),
    .out_bin_touched  (out_bin_touched),
    .out_sample_bucket(out_sample_bucket),
    .out_counted      (out_counted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the clearing sweep plus the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 50) $display("%0t: %s", $time, msg);
  endtask

  // bucket of one sample word under the current thresholds
  function automatic logic [BUCKET_W-1:0] bucket_for(input logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] coded;
    int ones;
    coded = cfg_gray ? (word ^ (word << 1)) : word;
    ones = $countones(coded);
    // low threshold wins when the two are crossed
    if (ones < cfg_low) return BKT_LOW;
    if (ones >= cfg_high) return BKT_HIGH;
    return BKT_MID;
  endfunction

  // advance our copy of the histogram by one item and return its result
  function automatic result_t predict_histogram_step(input logic [ACTION_W-1:0] act,
                                                     input logic [WORD_W-1:0] word,
                                                     input logic [BIN_W-1:0] sel);
    result_t r;
    logic [BIN_W-1:0] idx;
    r = '0;
    case (act)
      ACT_SAMPLE: begin
        r.sample_bucket = bucket_for(word);
        // priming samples only shift the window
        if (seen_count >= cfg_prime) begin
          idx = {window_buckets[3], window_buckets[2], window_buckets[1],
                 window_buckets[0], {1'b0, r.sample_bucket}};
          // counts stick at all ones
          if (bin_counts[idx] != '1) bin_counts[idx] = bin_counts[idx] + 1'b1;
          r.bin_count   = bin_counts[idx];
          r.bin_touched = idx;
          r.counted     = 1'b1;
          hot_bins.push_back(idx);
          if (hot_bins.size() > 32) void'(hot_bins.pop_front());
        end
        for (int k = WINDOW_LEN - 2; k > 0; k--) window_buckets[k] = window_buckets[k-1];
        window_buckets[0] = {1'b0, r.sample_bucket};
        if (seen_count != SEEN_MAX) seen_count++;
      end
      ACT_READ: begin
        r.bin_count   = bin_counts[sel];
        r.bin_touched = sel;
      end
      ACT_CLEAR: begin
        bin_counts[sel] = '0;
        r.bin_touched   = sel;
      end
      default: ;  // unused action leaves everything alone
    endcase
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GRAY_MODE: cfg_gray  = data[0];
      CFG_LOW_THR:   cfg_low   = data;
      CFG_HIGH_THR:  cfg_high  = data;
      CFG_PRIME_CNT: cfg_prime = data;
      default: ;
    endcase
  endfunction

  function automatic void plan_item(input logic [ACTION_W-1:0] act,
                                    input logic [WORD_W-1:0] word,
                                    input logic [BIN_W-1:0] sel,
                                    input bit has_fixed, input result_t fixed_want);
    row_t row;
    row = '{ROW_ITEM, act, word, sel, CFG_GRAY_MODE, '0, has_fixed, fixed_want};
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t row;
    row = '{ROW_REG, ACT_SAMPLE, '0, '0, idx, data, 1'b0, '0};
    directed_rows.push_back(row);
  endfunction

  // cfg_valid is left high so that back-to-back writes need no gap;
  // the next item offer drops it in the same step the write lands
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // offer one item, with a random idle gap in front, and hold it until taken
  task automatic offer_item(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] word,
                            input logic [BIN_W-1:0] sel, input bit has_fixed,
                            input result_t fixed_want);
    result_t predicted;
    cfg_valid <= 1'b0;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_sample_word <= word;
    in_bin_select  <= sel;
    do @(posedge clk); while (in_stall);
    predicted = predict_histogram_step(act, word, sel);
    // fixed rows still run through the predictor to keep its state in step
    expected_results.push_back(has_fixed ? fixed_want : predicted);
  endtask

  // stop offering until every expected result has come back
  task automatic wait_for_empty();
    if (expected_results.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  // receiver: random stalls per phase, plus a long hold-off when asked
  initial begin : receiver
    int unsigned hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result item with none expected: count %0h bin %0h",
                               out_bin_count, out_bin_touched));
      end else begin
        want = expected_results.pop_front();
        if (out_bin_count !== want.bin_count)
          report_error($sformatf("bin_count got %0h expected %0h",
                                 out_bin_count, want.bin_count));
        if (out_bin_touched !== want.bin_touched)
          report_error($sformatf("bin_touched got %0h expected %0h",
                                 out_bin_touched, want.bin_touched));
        if (out_sample_bucket !== want.sample_bucket)
          report_error($sformatf("sample_bucket got %0d expected %0d",
                                 out_sample_bucket, want.sample_bucket));
        if (out_counted !== want.counted)
          report_error($sformatf("counted got %0b expected %0b",
                                 out_counted, want.counted));
      end
    end
  end

  initial begin : stimulus
    row_t row;
    int pick;
    logic [ACTION_W-1:0] act;
    logic [WORD_W-1:0] word;
    logic [BIN_W-1:0] sel;

    // state after reset
    foreach (bin_counts[i]) bin_counts[i] = '0;
    foreach (window_buckets[i]) window_buckets[i] = '0;
    seen_count = '0;
    cfg_gray   = GRAY_MODE_RST;
    cfg_low    = LOW_THR_RST;
    cfg_high   = HIGH_THR_RST;
    cfg_prime  = PRIME_CNT_RST;

    // directed table; fixed results only where obvious at reset settings
    // empty histogram reads back zero at both ends of the index range
    plan_item(ACT_READ,   32'h0000_0000, 15'h0000, 1'b1, {64'd0, 15'h0000, BKT_LOW, 1'b0});
    plan_item(ACT_READ,   32'h0000_0000, 15'h7fff, 1'b1, {64'd0, 15'h7fff, BKT_LOW, 1'b0});
    // unused action: all fields zero
    plan_item(ACT_UNUSED, 32'hffff_ffff, 15'h7fff, 1'b1, '0);
    // priming samples carry only their bucket
    plan_item(ACT_SAMPLE, 32'h0000_0000, 15'h7fff, 1'b1, {64'd0, 15'h0000, BKT_LOW, 1'b0});
    // gray code of all ones has a single set bit
    plan_item(ACT_SAMPLE, 32'hffff_ffff, 15'h0000, 1'b1, {64'd0, 15'h0000, BKT_LOW, 1'b0});
    plan_item(ACT_SAMPLE, 32'h5555_5555, 15'h0000, 1'b1, {64'd0, 15'h0000, BKT_HIGH, 1'b0});
    plan_item(ACT_SAMPLE, 32'haaaa_aaaa, 15'h0000, 1'b1, {64'd0, 15'h0000, BKT_HIGH, 1'b0});
    plan_item(ACT_CLEAR,  32'h0000_0000, 15'h1234, 1'b1, {64'd0, 15'h1234, BKT_LOW, 1'b0});
    // prime count of zero: counting starts with the earlier priming buckets in the window
    plan_reg(CFG_PRIME_CNT, 6'd0);
    plan_item(ACT_SAMPLE, 32'h0000_ffff, 15'h0000, 1'b0, '0);
    plan_item(ACT_SAMPLE, 32'h0000_ffff, 15'h0000, 1'b0, '0);
    // gray coding off, upper data bits ignored
    plan_reg(CFG_GRAY_MODE, 6'h3e);
    plan_item(ACT_SAMPLE, 32'hffff_ffff, 15'h0000, 1'b0, '0);
    plan_item(ACT_SAMPLE, 32'h0000_0000, 15'h0000, 1'b0, '0);
    plan_item(ACT_SAMPLE, 32'h00ff_00ff, 15'h0000, 1'b0, '0);
    // crossed thresholds: low test comes first
    plan_reg(CFG_LOW_THR, 6'd33);
    plan_item(ACT_SAMPLE, 32'hffff_ffff, 15'h0000, 1'b0, '0);
    plan_reg(CFG_LOW_THR, 6'd0);
    plan_reg(CFG_HIGH_THR, 6'd0);
    plan_item(ACT_SAMPLE, 32'h0000_0000, 15'h0000, 1'b0, '0);
    plan_reg(CFG_HIGH_THR, 6'd33);
    plan_item(ACT_SAMPLE, 32'hffff_ffff, 15'h0000, 1'b0, '0);
    plan_item(ACT_SAMPLE, 32'hffff_ffff, 15'h0000, 1'b0, '0);
    plan_item(ACT_READ,   32'h0000_0000, 15'h1249, 1'b0, '0);
    plan_item(ACT_CLEAR,  32'hffff_ffff, 15'h1249, 1'b1, {64'd0, 15'h1249, BKT_LOW, 1'b0});
    // back to reset gray mode and thresholds, with the longest priming
    plan_reg(CFG_GRAY_MODE, 6'd1);
    plan_reg(CFG_LOW_THR, 6'd14);
    plan_reg(CFG_HIGH_THR, 6'd19);
    plan_reg(CFG_PRIME_CNT, 6'd63);
    plan_item(ACT_SAMPLE, 32'h1234_5678, 15'h0000, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // first item waits out the clearing sweep behind in_stall
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        wait_for_empty();
        write_reg(row.reg_index, row.reg_data);
      end else begin
        offer_item(row.action, row.word, row.sel, row.has_fixed, row.fixed_want);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      wait_for_empty();
      send_idle_pct  = SEND_IDLE_PCT[phase];
      recv_stall_pct = RECV_STALL_PCT[phase];
      case (phase)
        0: begin
          write_reg(CFG_GRAY_MODE, {5'($urandom), 1'b1});
          write_reg(CFG_LOW_THR, 6'd14);
          write_reg(CFG_HIGH_THR, 6'd19);
          write_reg(CFG_PRIME_CNT, 6'd4);
        end
        1: begin
          write_reg(CFG_GRAY_MODE, {5'($urandom), 1'b0});
          write_reg(CFG_LOW_THR, 6'd12);
          write_reg(CFG_HIGH_THR, 6'd21);
          write_reg(CFG_PRIME_CNT, 6'd63);
        end
        2: begin
          // crossed thresholds under random traffic
          write_reg(CFG_GRAY_MODE, {5'($urandom), 1'b1});
          write_reg(CFG_LOW_THR, 6'd20);
          write_reg(CFG_HIGH_THR, 6'd12);
          write_reg(CFG_PRIME_CNT, 6'd0);
        end
        default: begin
          write_reg(CFG_GRAY_MODE, 6'($urandom));
          write_reg(CFG_LOW_THR, 6'($urandom_range(0, 33)));
          write_reg(CFG_HIGH_THR, 6'($urandom_range(0, 33)));
          write_reg(CFG_PRIME_CNT, 6'($urandom_range(0, 63)));
        end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming: the block backs up
        if (phase == 0 && n == 40) hold_requests++;
        // sender pause until the block has drained
        if (phase == 2 && n == 112) wait_for_empty();

        pick = $urandom_range(0, 99);
        if (pick < 70)      act = ACT_SAMPLE;
        else if (pick < 82) act = ACT_READ;
        else if (pick < 94) act = ACT_CLEAR;
        else                act = ACT_UNUSED;

        // sparse and dense words push the bit count toward both outer buckets
        case ($urandom_range(0, 3))
          0:       word = $urandom;
          1:       word = $urandom & $urandom;
          2:       word = $urandom | $urandom;
          default: word = $urandom_range(0, 1) ? ($urandom & $urandom & $urandom)
                                               : ($urandom | $urandom | $urandom);
        endcase

        // reads and clears aim at a recently incremented bin half the time
        if (hot_bins.size() != 0 && $urandom_range(0, 1))
          sel = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        else
          sel = BIN_W'($urandom_range(0, N_BINS - 1));

        offer_item(act, word, sel, 1'b0, '0);
      end
    end

    wait_for_empty();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
